FILE: sv/xcrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xcrd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] StartByteReset    = 8'h00;
  localparam logic [TickW-1:0] TimeoutTicksReset = 16'd100;
  localparam logic [TickW-1:0] TickMax           = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE    = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_idx_t;

  // event kinds
  typedef enum logic [1:0] {
    FN_ARM    = 2'd0,
    FN_BYTE   = 2'd1,
    FN_TICK   = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HUNT   = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef struct packed {
    logic [1:0]       func;
    logic [ByteW-1:0] arm_len;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] data_byte;
    logic [1:0]       status;
    logic             last;
  } result_t;

  // handoff between the input register and the frame engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } staged_t;

endpackage
`default_nettype wire

FILE: sv/xcrd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface xcrd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] arm_len;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output arm_len, output rx_byte,
                  input ready);
  modport sink   (input valid, input func, input arm_len, input rx_byte,
                  output ready);
endinterface

interface xcrd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_index;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output byte_index, output data_byte,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input byte_index, input data_byte,
                  input status, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/xcrd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module xcrd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  xcrd_in_if.sink              in_bus,
  input  wire logic            take,
  output xcrd_pkg::staged_t    staged
);
  import xcrd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // room when empty or when the held beat moves on this cycle
  assign in_bus.ready = !valid_r || take;
  assign load         = in_bus.valid && in_bus.ready;
  assign valid_nxt    = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{func: in_bus.func, arm_len: in_bus.arm_len,
                  rx_byte: in_bus.rx_byte};
    end
  end

  assign staged = '{valid: valid_r, item: item_r};

endmodule
`default_nettype wire

FILE: sv/xcrd_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module xcrd_engine (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [xcrd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [xcrd_pkg::CfgDataW-1:0]  cfg_data,
  input  xcrd_pkg::staged_t                   staged,
  input  wire logic                           take,
  output logic                                res_valid,
  output xcrd_pkg::result_t                   res
);
  import xcrd_pkg::*;

  logic [ByteW-1:0] start_byte_r;
  logic [TickW-1:0] timeout_ticks_r;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] wanted_r, wanted_nxt;
  logic [ByteW-1:0] count_r, count_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic [TickW-1:0] elapsed_r, elapsed_nxt;

  logic             fire;
  func_t            func;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] count_inc;
  logic [TickW-1:0] elapsed_inc;
  logic             timed_out;

  assign fire        = staged.valid && take;
  assign func        = func_t'(staged.item.func);
  assign b           = staged.item.rx_byte;
  assign count_inc   = count_r + 1'b1;
  assign elapsed_inc = (elapsed_r != TickMax) ? elapsed_r + 1'b1 : elapsed_r;
  assign timed_out   = elapsed_inc >= timeout_ticks_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= StartByteReset;
      timeout_ticks_r <= TimeoutTicksReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_BYTE:    start_byte_r    <= cfg_data[ByteW-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    wanted_nxt  = wanted_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    elapsed_nxt = elapsed_r;
    if (fire) begin
      if (func == FN_ARM) begin
        wanted_nxt  = staged.item.arm_len;
        count_nxt   = '0;
        xor_nxt     = '0;
        elapsed_nxt = '0;
        phase_nxt   = PH_HUNT;
      end else if (phase_r != PH_IDLE) begin
        if (func == FN_TICK) begin
          elapsed_nxt = elapsed_inc;
          if (timed_out) phase_nxt = PH_IDLE;
        end else if (func == FN_BYTE) begin
          case (phase_r)
            PH_HUNT: begin
              if (b == start_byte_r) phase_nxt = PH_LENGTH;
            end
            PH_LENGTH: begin
              if (b != wanted_r) begin
                phase_nxt = PH_IDLE;
              end else begin
                xor_nxt   = b;
                count_nxt = '0;
                phase_nxt = (wanted_r == '0) ? PH_CHECK : PH_DATA;
              end
            end
            PH_DATA: begin
              xor_nxt   = xor_r ^ b;
              count_nxt = count_inc;
              if (count_inc >= wanted_r) phase_nxt = PH_CHECK;
            end
            PH_CHECK: phase_nxt = PH_IDLE;
            default:  phase_nxt = PH_IDLE;
          endcase
        end
      end
    end
  end

  // result for the current beat
  always_comb begin
    res_valid = 1'b0;
    res       = '{kind: KindPayload, byte_index: '0, data_byte: '0,
                  status: ST_OK, last: 1'b0};
    if (fire && func != FN_ARM && phase_r != PH_IDLE) begin
      if (func == FN_TICK) begin
        if (timed_out) begin
          res_valid  = 1'b1;
          res.kind   = KindStatus;
          res.status = ST_TIMEOUT;
          res.last   = 1'b1;
        end
      end else if (func == FN_BYTE) begin
        case (phase_r)
          PH_LENGTH: begin
            if (b != wanted_r) begin
              res_valid  = 1'b1;
              res.kind   = KindStatus;
              res.status = ST_LENGTH;
              res.last   = 1'b1;
            end
          end
          PH_DATA: begin
            res_valid      = 1'b1;
            res.byte_index = count_r;
            res.data_byte  = b;
          end
          PH_CHECK: begin
            res_valid  = 1'b1;
            res.kind   = KindStatus;
            res.status = (b == xor_r) ? ST_OK : ST_CHECKSUM;
            res.last   = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wanted_r  <= '0;
      count_r   <= '0;
      xor_r     <= '0;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      wanted_r  <= wanted_nxt;
      count_r   <= count_nxt;
      xor_r     <= xor_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/xcrd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module xcrd_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  xcrd_pkg::result_t  res,
  output logic               take,
  xcrd_out_if.source         out_bus
);
  import xcrd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // the register refills when empty or drained this cycle
  assign take = !valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_bus.valid      = valid_r;
  assign out_bus.kind       = res_r.kind;
  assign out_bus.byte_index = res_r.byte_index;
  assign out_bus.data_byte  = res_r.data_byte;
  assign out_bus.status     = res_r.status;
  assign out_bus.last       = res_r.last;

endmodule
`default_nettype wire

FILE: sv/xor_checked_response_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Deframer for responses of the form [start][length][data...][xor check]. Each
// input beat is one event: arm (expected length, clears the tick count), a
// received byte, or a timer tick. Payload bytes come out with their index; one
// status beat (ok, timeout, length mismatch, checksum error) with last set ends
// each armed frame that is not dropped by a re-arm. An event passes from the
// input register through the combinational frame engine into the output
// register, so a beat is accepted every cycle while the output side keeps up.
// Configuration (index 0 start byte, index 1 timeout in ticks) must be written
// by the user only while no frame work is pending; the block does not check.
module xor_checked_response_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [xcrd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [xcrd_pkg::CfgDataW-1:0]  cfg_data,
  xcrd_in_if.sink                             in_bus,
  xcrd_out_if.source                          out_bus
);
  import xcrd_pkg::*;

  staged_t staged;
  logic    take;
  logic    res_valid;
  result_t res;

  xcrd_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .take   (take),
    .staged (staged)
  );

  xcrd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .staged    (staged),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  xcrd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .out_bus   (out_bus)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import xcrd_pkg::*;

  localparam int ItemTarget = 1950;
  localparam int NumPhases  = 5;
  localparam int QuietLimit = 3000;
  localparam int HoldOff    = 300;
  localparam int Settle     = 6;
  localparam int IdlePct    = 23;

  // ways a generated frame can go wrong
  localparam int FlawNone    = 0;
  localparam int FlawLength  = 1;
  localparam int FlawCheck   = 2;
  localparam int FlawAbandon = 3;

  // frame tracker: mirrors the deframer state and holds the results still owed
  class deframe_scoreboard;
    logic [ByteW-1:0] start_val;
    logic [TickW-1:0] timeout_val;
    phase_t           phase;
    logic [ByteW-1:0] want_len;
    logic [ByteW-1:0] rx_count;
    logic [ByteW-1:0] xor_acc;
    logic [TickW-1:0] ticks;
    result_t          pending[$];
    int               errors;

    function new();
      start_val   = StartByteReset;
      timeout_val = TimeoutTicksReset;
      phase       = PH_IDLE;
      want_len    = '0;
      rx_count    = '0;
      xor_acc     = '0;
      ticks       = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_START_BYTE) start_val = val[ByteW-1:0];
      else timeout_val = val;
    endfunction

    // work out what one accepted event produces
    function void note_event(item_t ev);
      result_t r;
      bit      emit;
      emit = 1'b0;
      r    = '0;
      if (ev.func == FN_ARM) begin
        want_len = ev.arm_len;
        rx_count = '0;
        xor_acc  = '0;
        ticks    = '0;
        phase    = PH_HUNT;
      end else if (phase != PH_IDLE && ev.func == FN_TICK) begin
        if (ticks != TickMax) ticks++;
        if (ticks >= timeout_val) begin
          r.kind   = KindStatus;
          r.status = ST_TIMEOUT;
          emit     = 1'b1;
        end
      end else if (phase != PH_IDLE && ev.func == FN_BYTE) begin
        case (phase)
          PH_HUNT: begin
            if (ev.rx_byte == start_val) phase = PH_LENGTH;
          end
          PH_LENGTH: begin
            if (ev.rx_byte != want_len) begin
              r.kind   = KindStatus;
              r.status = ST_LENGTH;
              emit     = 1'b1;
            end else begin
              xor_acc  = ev.rx_byte;
              rx_count = '0;
              phase    = (want_len == 0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            r.kind       = KindPayload;
            r.byte_index = rx_count;
            r.data_byte  = ev.rx_byte;
            emit         = 1'b1;
            xor_acc      = xor_acc ^ ev.rx_byte;
            rx_count++;
            if (rx_count >= want_len) phase = PH_CHECK;
          end
          PH_CHECK: begin
            r.kind   = KindStatus;
            r.status = (ev.rx_byte == xor_acc) ? ST_OK : ST_CHECKSUM;
            emit     = 1'b1;
          end
          default: phase = PH_IDLE;
        endcase
      end
      // a status beat closes the frame
      if (emit && r.kind == KindStatus) begin
        r.last = 1'b1;
        phase  = PH_IDLE;
      end
      if (emit) pending.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one output beat with the oldest owed result
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("kind", 8'(want.kind), 8'(got.kind));
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  xcrd_in_if  in_bus ();
  xcrd_out_if out_bus ();

  xor_checked_response_deframer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  deframe_scoreboard sb;
  bit                src_idle_on;
  bit                sink_idle_on;
  bit                hold_req;
  int                tick_pct;
  int                sent_items;
  int                quiet;
  logic [ByteW-1:0]  cur_start;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // beat monitor on both channels, plus the stall watchdog
  always @(posedge clk) begin : beat_monitor
    item_t   ev;
    result_t res;
    bit      moved;
    moved = 1'b0;
    if (rst_n === 1'b1 && in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
      ev.func    = in_bus.func;
      ev.arm_len = in_bus.arm_len;
      ev.rx_byte = in_bus.rx_byte;
      sb.note_event(ev);
      moved = 1'b1;
    end
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      res.kind       = out_bus.kind;
      res.byte_index = out_bus.byte_index;
      res.data_byte  = out_bus.data_byte;
      res.status     = out_bus.status;
      res.last       = out_bus.last;
      sb.check_result(res);
      moved = 1'b1;
    end
    if (moved || rst_n !== 1'b1) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
      $display("** xor_checked_response_deframer: FAILED **");
      $finish;
    end
  end

  // result side: random backpressure, long hold-off on request
  initial begin : result_sink
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_bus.ready <= !(sink_idle_on && $urandom_range(99) < IdlePct);
      end
    end
  end

  // offer one event and hold it until accepted
  task automatic send_event(input func_t fn, input logic [7:0] len, input logic [7:0] b,
                            input bit counts = 1'b1);
    while (src_idle_on && $urandom_range(99) < IdlePct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.func    <= fn;
    in_bus.arm_len <= len;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    if (counts) sent_items++;
  endtask

  task automatic send_arm(input logic [7:0] len);
    send_event(FN_ARM, len, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_event(FN_BYTE, 8'($urandom), b);
  endtask

  task automatic send_tick();
    send_event(FN_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic maybe_ticks();
    while ($urandom_range(99) < tick_pct) send_tick();
  endtask

  // arm, hunt noise, start, length, payload, check byte; a flaw can corrupt or cut short
  task automatic send_frame(input logic [7:0] len, input int flaw);
    logic [7:0] b;
    logic [7:0] acc;
    int         n_noise;
    int         n_data;
    send_arm(len);
    n_noise = $urandom_range(2);
    repeat (n_noise) begin
      b = 8'($urandom);
      if (b == cur_start) b = b ^ 8'h01;
      maybe_ticks();
      send_byte(b);
    end
    maybe_ticks();
    send_byte(cur_start);
    maybe_ticks();
    if (flaw == FlawLength) begin
      send_byte(len ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_byte(len);
    acc    = len;
    n_data = (flaw == FlawAbandon) ? int'($urandom_range(len)) : int'(len);
    for (int i = 0; i < n_data; i++) begin
      b   = 8'($urandom);
      acc = acc ^ b;
      maybe_ticks();
      send_byte(b);
    end
    if (flaw == FlawAbandon) return;
    maybe_ticks();
    send_byte((flaw == FlawCheck) ? acc ^ 8'($urandom_range(1, 255)) : acc);
  endtask

  // mostly short frames, now and then a long one
  task automatic send_random_frame();
    int         pick;
    int         flaw;
    logic [7:0] len;
    pick = $urandom_range(99);
    if (pick == 0) len = 8'd255;
    else if (pick < 4) len = 8'($urandom);
    else len = 8'($urandom_range(6));
    pick = $urandom_range(99);
    if (pick < 10) flaw = FlawLength;
    else if (pick < 20) flaw = FlawCheck;
    else if (pick < 28) flaw = FlawAbandon;
    else flaw = FlawNone;
    send_frame(len, flaw);
  endtask

  task automatic send_noise();
    send_event(func_t'($urandom_range(3)), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  // both registers, back to back, block idle
  task automatic set_regs(input logic [7:0] start_val, input logic [15:0] timeout_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= {8'h00, start_val};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= timeout_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_START_BYTE, {8'h00, start_val});
    sb.set_reg(CFG_TIMEOUT_TICKS, timeout_val);
    cur_start = start_val;
  endtask

  // stop offering and let every owed result come out
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    sb             = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_START_BYTE;
    cfg_data       = '0;
    in_bus.valid   = 1'b0;
    in_bus.func    = FN_ARM;
    in_bus.arm_len = '0;
    in_bus.rx_byte = '0;
    cur_start      = StartByteReset;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    tick_pct       = 0;
    sent_items     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes and ticks while idle, and the unused kind, are dropped
    send_event(FN_BYTE, 8'hFF, 8'hFF);
    send_event(FN_TICK, 8'h00, 8'h00);
    send_event(FN_UNUSED, 8'hFF, 8'hFF);
    // one-byte frame with the reset start byte
    send_arm(8'd1);
    send_byte(8'h00);
    send_byte(8'd1);
    send_byte(8'hFF);
    send_byte(8'hFE);
    wait_drained();
    set_regs(8'hFF, 16'd3);
    // wrong check byte
    send_arm(8'd1);
    send_byte(8'hFF);
    send_byte(8'd1);
    send_byte(8'h80);
    send_byte(8'h80);
    // length mismatch after a noise byte in the hunt
    send_arm(8'd9);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'd8);
    // zero length: the check byte equals the length byte
    send_arm(8'd0);
    send_byte(8'hFF);
    send_byte(8'd0);
    send_byte(8'd0);
    // re-arm drops the open frame, then timeout while hunting
    send_arm(8'd4);
    send_byte(8'hFF);
    send_byte(8'd4);
    send_byte(8'h11);
    send_arm(8'h80);
    send_tick();
    send_tick();
    send_tick();
    wait_drained();
    set_regs(8'h3C, 16'd0);
    // zero timeout fires on the first tick, here while waiting for the length
    send_arm(8'd2);
    send_byte(8'h3C);
    send_tick();

    // random phases, each with its own settings
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: begin
          set_regs(StartByteReset, TimeoutTicksReset);
          tick_pct = 5;
          hold_req = 1'b1;
        end
        1: begin
          set_regs(8'hFF, TickMax);
          tick_pct     = 10;
          src_idle_on  = 1'b0;
          sink_idle_on = 1'b0;
        end
        2: begin
          set_regs(8'($urandom), 16'($urandom_range(20, 200)));
          tick_pct     = 8;
          src_idle_on  = 1'b1;
          sink_idle_on = 1'b1;
        end
        3: begin
          set_regs(8'h7E, 16'd5);
          tick_pct = 15;
        end
        default: begin
          set_regs(8'($urandom), 16'd1);
          tick_pct = 3;
        end
      endcase
      // full-size frame reaches the last byte index
      if (p == 1) send_frame(8'd255, FlawNone);
      target = sent_items + (ItemTarget - sent_items) / (NumPhases - p);
      while (sent_items < target) begin
        if ($urandom_range(99) < 10) send_noise();
        else send_random_frame();
      end
      // finish with a clean frame so the block is idle for the next settings
      tick_pct = 0;
      send_frame(8'd1, FlawNone);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** xor_checked_response_deframer: PASSED **");
    end else begin
      $display("** xor_checked_response_deframer: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/xcrd_pkg.sv
sv/xcrd_ifs.sv
sv/xcrd_in_stage.sv
sv/xcrd_engine.sv
sv/xcrd_out_stage.sv
sv/xor_checked_response_deframer.sv
tb/sv/tb.sv
